### hdl/orm_pkg.sv
// Package for the optimal replacement miss counter.
// Shared constants, cell control struct and selection modes; no dependencies.
package orm_pkg;

    localparam int MAX_SLOTS    = 16;
    localparam int MAX_REQUESTS = 128;
    localparam int ID_W         = 16;
    localparam int LEN_W        = $clog2(MAX_REQUESTS + 1);
    localparam int ADDR_W       = $clog2(MAX_REQUESTS);
    localparam int DRV_W        = 5;
    localparam int CNT_W        = 8;

    typedef enum logic [2:0] {
        SEL_FREE   = 3'b001,
        SEL_ACTIVE = 3'b010,
        SEL_UNF    = 3'b100
    } sel_mode_t;

    typedef struct packed {
        logic              clear;
        logic              scan_init;
        logic              scan_cmp;
        logic              install;
        sel_mode_t         mode;
        logic [ID_W-1:0]   x;
        logic [ID_W-1:0]   cmp_id;
    } cell_ctrl_t;

endpackage

### hdl/orm_cell.sv
// One slot cell: holds an entry, its valid bit and its not-yet-requested flag.
// Passes the selection token to its neighbour. Depends on orm_pkg.
module orm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  orm_pkg::cell_ctrl_t ctrl,
    input  logic              active,
    input  logic              take_in,
    output logic              take_out,
    output logic              hit,
    output logic              occupied,
    output logic              unf_out
);
    import orm_pkg::*;

    logic [ID_W-1:0] content_reg;
    logic            valid_reg;
    logic            unf_reg;
    logic            unf_n;
    logic            cand;
    logic            sel;

    assign hit      = valid_reg && (content_reg == ctrl.x);
    assign occupied = valid_reg || !active;
    assign unf_n    = ctrl.scan_cmp ? (unf_reg && (content_reg != ctrl.cmp_id)) : unf_reg;
    assign unf_out  = unf_n;

    always_comb
    begin
        case (ctrl.mode)
            SEL_FREE:   cand = active && !valid_reg;
            SEL_ACTIVE: cand = active;
            SEL_UNF:    cand = unf_n;
            default:    cand = 1'b0;
        endcase
    end

    assign sel      = take_in && cand;
    assign take_out = take_in && !cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            unf_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
                valid_reg <= 1'b0;
            else if (ctrl.install && sel)
                valid_reg <= 1'b1;
            if (ctrl.scan_init)
                unf_reg <= active;
            else if (ctrl.scan_cmp)
                unf_reg <= unf_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.install && sel)
            content_reg <= ctrl.x;
    end

endmodule

### hdl/optimal_replacement_miss_count_top.sv
// Optimal replacement miss counter: request memory, sequencer, row of slot cells.
// Load writes each request to the memory. Compute: fetch and check per request, plus
// a read and a compare per future request scanned on an eviction (single read port).
// The result strobes in the cycle after compute ends; the receiver cannot stall.
// Reset (rst_n, async, low) empties the sequence, clears slots and sets nd_reg to 1.
module optimal_replacement_miss_count_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 request_id,
    input  logic                        last_request,
    input  logic                        cfg_we,
    input  logic [orm_pkg::DRV_W-1:0]   cfg_wdata,
    output logic                        done,
    output logic [7:0]                  miss_count,
    output logic                        overflow
);
    import orm_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_SREAD = 5'b01000,
        ST_SCMP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [DRV_W-1:0]  nd_reg;
    logic [DRV_W-1:0]  nd_eff;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  miss_reg, miss_next;
    logic [ID_W-1:0]   x_reg, x_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic              ovf_out_reg;

    logic [ID_W-1:0]   mem [MAX_REQUESTS];
    logic [ID_W-1:0]   rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    cell_ctrl_t        ctrl;
    logic [MAX_SLOTS:0]   take;
    logic [MAX_SLOTS-1:0] hit_v, occ_v, unf_v, active_v;

    always_comb
    begin
        if (nd_reg == '0)
            nd_eff = DRV_W'(1);
        else if (nd_reg > DRV_W'(MAX_SLOTS))
            nd_eff = DRV_W'(MAX_SLOTS);
        else
            nd_eff = nd_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_cell
            assign active_v[g] = (DRV_W'(g) < nd_eff);
            orm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .active   (active_v[g]),
                .take_in  (take[g]),
                .take_out (take[g+1]),
                .hit      (hit_v[g]),
                .occupied (occ_v[g]),
                .unf_out  (unf_v[g])
            );
        end
    endgenerate
    assign take[0] = 1'b1;

    assign busy = (state_reg != ST_LOAD);
    assign wr_en = (state_reg == ST_LOAD) && start && (len_reg < LEN_W'(MAX_REQUESTS));
    assign rd_addr = (state_reg == ST_SREAD) ? j_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[len_reg[ADDR_W-1:0]] <= request_id;
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        miss_next  = miss_reg;
        x_next     = x_reg;
        done_next  = 1'b0;
        ctrl       = '0;
        ctrl.mode  = SEL_FREE;
        ctrl.x     = x_reg;
        ctrl.cmp_id = rdata_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (len_reg < LEN_W'(MAX_REQUESTS))
                        len_next = len_reg + LEN_W'(1);
                    else
                        ovf_next = 1'b1;
                    if (last_request)
                    begin
                        ctrl.clear = 1'b1;
                        i_next     = '0;
                        miss_next  = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                if (i_reg >= len_reg)
                begin
                    done_next  = 1'b1;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ctrl.x = rdata_reg;
                x_next = rdata_reg;
                if (|hit_v)
                begin
                    i_next     = i_reg + LEN_W'(1);
                    state_next = ST_FETCH;
                end
                else
                begin
                    if (miss_reg != '1)
                        miss_next = miss_reg + CNT_W'(1);
                    if (!(&occ_v))
                    begin
                        // fill the lowest free slot
                        ctrl.install = 1'b1;
                        i_next       = i_reg + LEN_W'(1);
                        state_next   = ST_FETCH;
                    end
                    else if (nd_eff == DRV_W'(1) || (i_reg + LEN_W'(1)) >= len_reg)
                    begin
                        // one slot or no future to scan: evict the lowest slot
                        ctrl.mode    = SEL_ACTIVE;
                        ctrl.install = 1'b1;
                        i_next       = i_reg + LEN_W'(1);
                        state_next   = ST_FETCH;
                    end
                    else
                    begin
                        ctrl.scan_init = 1'b1;
                        j_next         = i_reg + LEN_W'(1);
                        state_next     = ST_SREAD;
                    end
                end
            end
            ST_SREAD:
            begin
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                ctrl.scan_cmp = 1'b1;
                ctrl.mode     = SEL_UNF;
                // one slot left unrequested, or scan exhausted: evict lowest unrequested
                if ($onehot(unf_v) || (j_reg + LEN_W'(1)) >= len_reg)
                begin
                    ctrl.install = 1'b1;
                    i_next       = i_reg + LEN_W'(1);
                    state_next   = ST_FETCH;
                end
                else
                begin
                    j_next     = j_reg + LEN_W'(1);
                    state_next = ST_SREAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            nd_reg    <= DRV_W'(1);
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            miss_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                nd_reg <= cfg_wdata;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            miss_reg  <= miss_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (done_next)
        begin
            cnt_out_reg <= miss_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign done       = done_reg;
    assign miss_count = cnt_out_reg;
    assign overflow   = ovf_out_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding computation");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_REQUESTS))
        else $error("sequence length beyond store depth");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (len_reg == '0 && !ovf_reg && !busy))
        else $error("sequence not emptied after result");
`endif

endmodule

### test/optimal_replacement_miss_count_top_tb.sv
// Testbench for the optimal replacement miss counter: drives request sequences and
// drive-count settings, predicts each insertion count by Belady replacement.
// Depends on orm_pkg and optimal_replacement_miss_count_top.
`timescale 1ns / 1ps

class miss_count_board;
    logic [15:0] seq_ids[$];
    logic        seq_over;
    logic [4:0]  drives;
    logic [7:0]  exp_count[$];
    logic        exp_over[$];
    int          mismatches;

    function new();
        seq_over   = 1'b0;
        drives     = 5'd1;
        mismatches = 0;
    endfunction

    function int next_request(int from, logic [15:0] id);
        for (int j = from; j < seq_ids.size(); j++)
            if (seq_ids[j] == id)
                return j;
        return seq_ids.size();
    endfunction

    function logic [7:0] belady_misses();
        int          nd;
        int          misses;
        int          target;
        int          best;
        int          d;
        bit          hit;
        logic [15:0] slot_id[orm_pkg::MAX_SLOTS];
        bit          slot_used[orm_pkg::MAX_SLOTS];
        nd = drives;
        if (nd == 0)
            nd = 1;
        if (nd > orm_pkg::MAX_SLOTS)
            nd = orm_pkg::MAX_SLOTS;
        misses = 0;
        foreach (slot_used[s])
            slot_used[s] = 1'b0;
        for (int i = 0; i < seq_ids.size(); i++)
        begin
            hit = 1'b0;
            for (int s = 0; s < nd; s++)
                if (slot_used[s] && slot_id[s] == seq_ids[i])
                    hit = 1'b1;
            if (hit)
                continue;
            if (misses < 255)
                misses++;
            target = -1;
            for (int s = nd - 1; s >= 0; s--)
                if (!slot_used[s])
                    target = s;
            if (target < 0)
            begin
                // evict the farthest next request; ties keep the lowest slot
                target = 0;
                best   = 0;
                for (int s = 0; s < nd; s++)
                begin
                    d = next_request(i + 1, slot_id[s]);
                    if (s == 0 || d > best)
                    begin
                        best   = d;
                        target = s;
                    end
                end
            end
            slot_id[target]   = seq_ids[i];
            slot_used[target] = 1'b1;
        end
        return misses[7:0];
    endfunction

    function void note_request(logic [15:0] id, logic last);
        if (seq_ids.size() < orm_pkg::MAX_REQUESTS)
            seq_ids = {seq_ids, id};
        else
            seq_over = 1'b1;
        if (last)
        begin
            exp_count = {exp_count, belady_misses()};
            exp_over  = {exp_over, seq_over};
            seq_ids.delete();
            seq_over = 1'b0;
        end
    endfunction

    function void check_result(logic [7:0] count, logic over);
        logic [7:0] e_count;
        logic       e_over;
        if (exp_count.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: count %0d overflow %0b", count, over);
            return;
        end
        e_count = exp_count.pop_front();
        e_over  = exp_over.pop_front();
        if (count !== e_count || over !== e_over)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                         e_count, count, e_over, over);
        end
    endfunction
endclass

module optimal_replacement_miss_count_top_tb;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] request_id;
    logic        last_request;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        done;
    logic [7:0]  miss_count;
    logic        overflow;

    miss_count_board board;
    bit          idle_on;
    int          cycles;
    int          sent;

    optimal_replacement_miss_count_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request_id      (request_id),
        .last_request    (last_request),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .miss_count      (miss_count),
        .overflow        (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && done)
            board.check_result(miss_count, overflow);

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // start stays high between items; drop it only for an idle gap or in drain
    task automatic send_request(logic [15:0] id, logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start        <= 1'b1;
        request_id   <= id;
        last_request <= last;
        // hold until accepted
        do
            @(posedge clk);
        while (busy);
        board.note_request(id, last);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.exp_count.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_drives(logic [4:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.drives = value;
    endtask

    task automatic send_sequence(int len, int id_span);
        for (int i = 0; i < len; i++)
            send_request(id_span >= 65535 ? 16'($urandom) : 16'($urandom_range(0, id_span)),
                         i == len - 1);
    endtask

    initial
    begin
        int len;
        board        = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        request_id   = '0;
        last_request = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        idle_on      = 1'b0;
        sent         = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: single request, field extremes, reset drive count
        send_request(16'h0000, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        // drive count zero acts as one, above sixteen as sixteen
        set_drives(5'd0);
        send_sequence(5, 3);
        set_drives(5'd31);
        send_sequence(6, 40);
        set_drives(5'd16);
        send_sequence(6, 20);
        // never-requested entries tie
        set_drives(5'd2);
        send_request(16'd1, 1'b0);
        send_request(16'd2, 1'b0);
        send_request(16'd3, 1'b1);
        // overflow: sequence longer than the store
        set_drives(5'd3);
        send_sequence(orm_pkg::MAX_REQUESTS + 3, 10);

        idle_on = 1'b1;
        while (sent < 1300)
        begin
            if ($urandom_range(0, 3) == 0)
                set_drives(5'($urandom_range(0, 31)));
            len = ($urandom_range(0, 30) == 0) ? $urandom_range(120, 140)
                                                : $urandom_range(1, 24);
            // narrow id spans give hits and evictions
            send_sequence(len, ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(1, 20));
            if (sent > 1150)
                idle_on = 1'b0;
        end
        // one slot and two ids over a full store: a miss on the first item and whenever the id changes
        set_drives(5'd1);
        send_sequence(orm_pkg::MAX_REQUESTS, 1);
        while (sent < 1500)
            send_sequence($urandom_range(1, 20), $urandom_range(1, 12));

        drain();
        repeat (2000) @(negedge clk);
        if (board.mismatches == 0 && board.exp_count.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### filelist.f
hdl/orm_pkg.sv
hdl/orm_cell.sv
hdl/optimal_replacement_miss_count_top.sv
test/optimal_replacement_miss_count_top_tb.sv
